// File: hdl/vwd_pkg.sv
// Package for the vertex weld dedup block: sizes, hash and scaling constants,
// and the table entry layout. No dependencies.
`timescale 1ns / 1ps
package vwd_pkg;
  localparam int PATCH_CAP   = 1024;
  localparam int TABLE_SLOTS = 8192;
  localparam int ID_LIMIT    = 4096;
  localparam int ID_W        = 12;
  localparam int KEY_W       = 64;
  localparam int POS_W       = 32;
  localparam int MAXP_W      = 11;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int PROBE_W     = $clog2(TABLE_SLOTS + 1);
  localparam int NV_W        = $clog2(ID_LIMIT + 1);
  localparam int PC_W        = $clog2(PATCH_CAP + 1);
  localparam int CMP_W       = (PC_W > MAXP_W) ? PC_W : MAXP_W;
  localparam int MULB_W      = 12;
  localparam int ENTRY_W     = 1 + ID_W + KEY_W;

  localparam logic [KEY_W-1:0]  FNV_BASIS   = 64'hCBF29CE484222325;
  localparam logic [MULB_W-1:0] FNV_PRIME_LO = 12'h1B3;
  localparam int                FNV_SHIFT   = 40;
  localparam logic [MULB_W-1:0] SCALE_MUL   = 12'd3125;
  localparam logic [KEY_W-1:0]  ROUND_ADD   = 64'd1024;
  localparam int                SCALE_SHIFT = 11;

  localparam logic [MAXP_W-1:0] MAXP_RESET  = MAXP_W'(PATCH_CAP);
  localparam logic [2:0]        REG_MAXP_ADDR = 3'd0;

  localparam logic OP_CLEAR  = 1'b0;
  localparam logic OP_CORNER = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;
endpackage

// File: hdl/vwd_in_if.sv
// Input and result channel interfaces of the vertex weld dedup block.
// Depends on vwd_pkg.
`timescale 1ns / 1ps
interface vwd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [vwd_pkg::POS_W-1:0] pos_x;
  logic signed [vwd_pkg::POS_W-1:0] pos_y;
  logic signed [vwd_pkg::POS_W-1:0] pos_z;
  modport source (output valid, op, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, op, pos_x, pos_y, pos_z, output ready);
endinterface

interface vwd_out_if;
  logic                     valid;
  logic                     ready;
  logic [vwd_pkg::ID_W-1:0] vertex_id;
  logic                     is_new;
  logic                     dropped;
  logic                     table_full;
  modport source (output valid, vertex_id, is_new, dropped, table_full, input ready);
  modport sink (input valid, vertex_id, is_new, dropped, table_full, output ready);
endinterface

// File: hdl/vwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/vwd_mulu.sv
// Shared multiplier: 64-bit word times 12-bit operand, product modulo 2^64.
// Depends on vwd_pkg.
`timescale 1ns / 1ps
module vwd_mulu (
  input  logic [vwd_pkg::KEY_W-1:0]  a,
  input  logic [vwd_pkg::MULB_W-1:0] b,
  output logic [vwd_pkg::KEY_W-1:0]  p
);
  logic [vwd_pkg::KEY_W+vwd_pkg::MULB_W-1:0] full_p;

  always_comb begin
    full_p = a * b;
    p      = full_p[vwd_pkg::KEY_W-1:0];
  end
endmodule

// File: hdl/vertex_weld_dedup_top.sv
// Top level of the vertex weld dedup block: sequencer, APB register, key table.
// Depends on vwd_pkg, vwd_in_if, vwd_out_if, vwd_ram, vwd_mulu.
//
// channel  dir   handshake        payload
// in_ch    in    valid/ready      op, pos_x, pos_y, pos_z
// out_ch   out   valid/ready      vertex_id, is_new, dropped, table_full
// cfg_*    in    APB write/read   max_patches at byte address 0
//
// A corner is accepted in S_IDLE, scaled and hashed on the shared multiplier in
// S_SCALE, S_ROUND and S_MIX per coordinate, probed in S_PROBE and S_CHECK per
// table probe, then posted from S_DONE. A dropped corner skips to S_DONE. Reset
// and a clear transaction sweep all TABLE_SLOTS (8192) slots, taking no input.
// A result waits in the output register while the next transaction is taken;
// posting stalls while that register is full and not accepted.
`timescale 1ns / 1ps
module vertex_weld_dedup_top (
  input  logic        clk,
  input  logic        rst_n,
  vwd_in_if.sink      in_ch,
  vwd_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCALE, S_ROUND, S_MIX, S_PROBE, S_CHECK, S_DONE
  } state_t;

  state_t                          state_r;
  logic [vwd_pkg::MAXP_W-1:0]      max_patches_r;
  logic [vwd_pkg::SLOT_W-1:0]      clr_addr_r;
  logic [vwd_pkg::POS_W-1:0]       pos_r [3];
  logic [1:0]                      coord_r;
  logic                            neg_r;
  logic [vwd_pkg::KEY_W-1:0]       prod_r;
  logic [vwd_pkg::KEY_W-1:0]       x_r;
  logic [vwd_pkg::KEY_W-1:0]       h_r;
  logic [vwd_pkg::SLOT_W-1:0]      slot_r;
  logic [vwd_pkg::PROBE_W-1:0]     probe_r;
  logic [vwd_pkg::NV_W-1:0]        next_vertex_r;
  logic [vwd_pkg::PC_W-1:0]        patch_count_r;
  logic [1:0]                      phase_r;
  logic [vwd_pkg::ID_W-1:0]        res_id_r;
  logic                            res_new_r;
  logic                            res_drop_r;
  logic                            res_full_r;
  logic                            out_valid_r;
  logic [vwd_pkg::ID_W-1:0]        out_id_r;
  logic                            out_new_r;
  logic                            out_drop_r;
  logic                            out_full_r;

  logic [vwd_pkg::POS_W-1:0]       raw;
  logic [vwd_pkg::POS_W-1:0]       mag;
  logic [vwd_pkg::KEY_W-1:0]       qmag;
  logic [vwd_pkg::KEY_W-1:0]       q;
  logic [vwd_pkg::KEY_W-1:0]       mul_a;
  logic [vwd_pkg::MULB_W-1:0]      mul_b;
  logic [vwd_pkg::KEY_W-1:0]       mul_p;
  logic [vwd_pkg::CMP_W-1:0]       limit;
  logic                            ram_we;
  logic [vwd_pkg::SLOT_W-1:0]      ram_waddr;
  vwd_pkg::entry_t                 ram_wdata;
  vwd_pkg::entry_t                 ram_rdata;
  logic [vwd_pkg::ENTRY_W-1:0]     ram_rbits;
  logic                            in_fire;
  logic                            out_load;
  logic                            cfg_wr;

  vwd_mulu u_mulu (.a(mul_a), .b(mul_b), .p(mul_p));

  vwd_ram #(.WIDTH(vwd_pkg::ENTRY_W), .DEPTH(vwd_pkg::TABLE_SLOTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_r),
    .rdata (ram_rbits)
  );

  assign ram_rdata = ram_rbits;

  always_comb begin
    raw  = pos_r[coord_r];
    mag  = raw[vwd_pkg::POS_W-1] ? (~raw + 1'b1) : raw;
    qmag = (prod_r + vwd_pkg::ROUND_ADD) >> vwd_pkg::SCALE_SHIFT;
    q    = neg_r ? (~qmag + 1'b1) : qmag;
    if (state_r == S_SCALE) begin
      mul_a = {{(vwd_pkg::KEY_W-vwd_pkg::POS_W){1'b0}}, mag};
      mul_b = vwd_pkg::SCALE_MUL;
    end else begin
      mul_a = x_r;
      mul_b = vwd_pkg::FNV_PRIME_LO;
    end
    if (vwd_pkg::CMP_W'(max_patches_r) < vwd_pkg::CMP_W'(vwd_pkg::PATCH_CAP)) begin
      limit = vwd_pkg::CMP_W'(max_patches_r);
    end else begin
      limit = vwd_pkg::CMP_W'(vwd_pkg::PATCH_CAP);
    end
  end

  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = slot_r;
    ram_wdata.valid = 1'b1;
    ram_wdata.id    = next_vertex_r[vwd_pkg::ID_W-1:0];
    ram_wdata.key   = h_r;
    if (state_r == S_CLEAR) begin
      ram_we          = 1'b1;
      ram_waddr       = clr_addr_r;
      ram_wdata.valid = 1'b0;
    end else if (state_r == S_CHECK && !ram_rdata.valid &&
                 next_vertex_r < vwd_pkg::NV_W'(vwd_pkg::ID_LIMIT)) begin
      ram_we = 1'b1;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.vertex_id  = out_id_r;
  assign out_ch.is_new     = out_new_r;
  assign out_ch.dropped    = out_drop_r;
  assign out_ch.table_full = out_full_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == vwd_pkg::REG_MAXP_ADDR[2]);
  assign cfg_prdata = (cfg_paddr[2] == vwd_pkg::REG_MAXP_ADDR[2]) ?
                      {{(32-vwd_pkg::MAXP_W){1'b0}}, max_patches_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      max_patches_r <= vwd_pkg::MAXP_RESET;
      next_vertex_r <= '0;
      patch_count_r <= '0;
      phase_r       <= '0;
      out_valid_r   <= 1'b0;
      coord_r       <= '0;
      probe_r       <= '0;
    end else begin
      if (cfg_wr) begin
        max_patches_r <= cfg_pwdata[vwd_pkg::MAXP_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_id_r    <= res_id_r;
        out_new_r   <= res_new_r;
        out_drop_r  <= res_drop_r;
        out_full_r  <= res_full_r;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == vwd_pkg::SLOT_W'(vwd_pkg::TABLE_SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.op == vwd_pkg::OP_CLEAR) begin
              next_vertex_r <= '0;
              patch_count_r <= '0;
              phase_r       <= '0;
              clr_addr_r    <= '0;
              state_r       <= S_CLEAR;
            end else if (phase_r == 2'd0 &&
                         vwd_pkg::CMP_W'(patch_count_r) >= limit) begin
              res_id_r   <= '0;
              res_new_r  <= 1'b0;
              res_drop_r <= 1'b1;
              res_full_r <= 1'b0;
              state_r    <= S_DONE;
            end else begin
              pos_r[0] <= in_ch.pos_x;
              pos_r[1] <= in_ch.pos_y;
              pos_r[2] <= in_ch.pos_z;
              coord_r  <= '0;
              h_r      <= vwd_pkg::FNV_BASIS;
              state_r  <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          prod_r  <= mul_p;
          neg_r   <= raw[vwd_pkg::POS_W-1];
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          x_r     <= h_r ^ q;
          state_r <= S_MIX;
        end
        S_MIX: begin
          h_r <= (x_r << vwd_pkg::FNV_SHIFT) + mul_p;
          if (coord_r == 2'd2) begin
            probe_r <= '0;
            slot_r  <= mul_p[vwd_pkg::SLOT_W-1:0];
            state_r <= S_PROBE;
          end else begin
            coord_r <= coord_r + 1'b1;
            state_r <= S_SCALE;
          end
        end
        S_PROBE: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          res_drop_r <= 1'b0;
          if (!ram_rdata.valid || ram_rdata.key == h_r ||
              probe_r == vwd_pkg::PROBE_W'(vwd_pkg::TABLE_SLOTS - 1)) begin
            phase_r <= phase_r + 1'b1;
            if (phase_r == 2'd3) begin
              patch_count_r <= patch_count_r + 1'b1;
            end
            state_r <= S_DONE;
            if (ram_rdata.valid && ram_rdata.key == h_r) begin
              res_id_r   <= ram_rdata.id;
              res_new_r  <= 1'b0;
              res_full_r <= 1'b0;
            end else if (!ram_rdata.valid &&
                         next_vertex_r < vwd_pkg::NV_W'(vwd_pkg::ID_LIMIT)) begin
              res_id_r      <= next_vertex_r[vwd_pkg::ID_W-1:0];
              res_new_r     <= 1'b1;
              res_full_r    <= 1'b0;
              next_vertex_r <= next_vertex_r + 1'b1;
            end else begin
              res_id_r   <= '0;
              res_new_r  <= 1'b0;
              res_full_r <= 1'b1;
            end
          end else begin
            slot_r  <= slot_r + 1'b1;
            probe_r <= probe_r + 1'b1;
            state_r <= S_PROBE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
